// ----- hdl/chained_hash_table_assert.svh -----
// Assertion macros shared by the checker.
`ifndef CHAINED_HASH_TABLE_ASSERT_SVH
`define CHAINED_HASH_TABLE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define CHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define CHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- hdl/cht_pkg.sv -----
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types and status codes of the chained hash table.
// ----------------------------------------------------------------------------
package cht_pkg;
  localparam int unsigned KeyW = 31;
  localparam int unsigned AgeW = 8;
  localparam int unsigned HdlW = 16;
  localparam int unsigned StW  = 3;

  typedef enum logic [StW-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_MISSING   = 3'd4
  } status_e;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } opcode_e;

  typedef struct packed {
    logic              op;
    logic [KeyW-1:0]   key;
    logic [AgeW-1:0]   age;
    logic [HdlW-1:0]   name;
    logic [HdlW-1:0]   city;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_READ,
    S_CHECK,
    S_DONE
  } bstate_e;
endpackage

// ----- hdl/cht_front.sv -----
// ----------------------------------------------------------------------------
// cht_front
// Accepts commands and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module cht_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  cht_pkg::cmd_t cmd_i,
  output logic          busy_o,
  output logic          q_valid_o,
  output cht_pkg::cmd_t q_cmd_o,
  input  logic          q_pop_i
);
  import cht_pkg::*;

  // Two-entry queue; a slot is full while a command waits for the back end.
  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push;

  assign busy_o    = (cnt_q == 2'd2);
  assign push      = start_i && !busy_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_cmd_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end
endmodule

// ----- hdl/cht_back.sv -----
// ----------------------------------------------------------------------------
// cht_back
// Walks the bucket chain in node memory and performs insert or search.
// ----------------------------------------------------------------------------
module cht_back #(
  parameter int unsigned BUCKETS = 16,
  parameter int unsigned NODES   = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  cht_pkg::cmd_t          q_cmd_i,
  output logic                   q_pop_o,
  output logic                   done_o,
  output cht_pkg::status_e       status_o,
  output logic [cht_pkg::AgeW-1:0] age_o,
  output logic [cht_pkg::HdlW-1:0] name_o,
  output logic [cht_pkg::HdlW-1:0] city_o
);
  import cht_pkg::*;

  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned CW = $clog2(NODES + 1);

  // Bucket table: head pointer with valid bit per bucket.
  logic [NW-1:0] head_q [BUCKETS];
  logic [BUCKETS-1:0] hvld_q;
  // Node memory: key, payload and link with valid flag.
  logic [KeyW-1:0] nkey_m [NODES];
  logic [AgeW-1:0] nage_m [NODES];
  logic [HdlW-1:0] nname_m [NODES];
  logic [HdlW-1:0] ncity_m [NODES];
  logic [NW:0]     nlink_m [NODES];

  logic [KeyW-1:0] rkey_q;
  logic [AgeW-1:0] rage_q;
  logic [HdlW-1:0] rname_q, rcity_q;
  logic [NW:0]     rlink_q;

  bstate_e       st_q, st_d;
  cmd_t          cmd_q;
  logic [NW-1:0] cur_q, cur_d;
  logic [CW-1:0] used_q;
  logic [BW-1:0] bkt;
  logic          hit, last;
  logic          mem_wr, link_wr, head_wr;

  // Bucket is the key's low bits when BUCKETS is a power of two.
  always_comb begin
    bkt = BW'(q_cmd_i.key % BUCKETS);
    if (st_q != S_IDLE) bkt = BW'(cmd_q.key % BUCKETS);
  end

  assign hit  = (rkey_q == cmd_q.key);
  assign last = !rlink_q[NW];
  assign q_pop_o = (st_q == S_IDLE) && q_valid_i;

  always_comb begin
    st_d = st_q;
    cur_d = cur_q;
    case (st_q)
      S_IDLE:  if (q_valid_i) st_d = S_HEAD;
      S_HEAD: begin
        cur_d = head_q[bkt];
        st_d  = hvld_q[bkt] ? S_READ : S_DONE;
      end
      S_READ:  st_d = S_CHECK;
      S_CHECK: begin
        if (hit || last) st_d = S_DONE;
        else begin
          cur_d = rlink_q[NW-1:0];
          st_d  = S_READ;
        end
      end
      S_DONE:  st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  // Result decision in S_DONE; found means last checked node matched.
  logic found_q;
  logic full;
  assign full = (used_q == CW'(NODES));

  always_comb begin
    done_o = (st_q == S_DONE);
    status_o = ST_MISSING;
    age_o = '0; name_o = '0; city_o = '0;
    mem_wr = 1'b0; link_wr = 1'b0; head_wr = 1'b0;
    if (st_q == S_DONE) begin
      if (cmd_q.op == OP_SEARCH) begin
        if (found_q) begin
          status_o = ST_FOUND;
          age_o = rage_q; name_o = rname_q; city_o = rcity_q;
        end
      end else if (found_q) status_o = ST_DUPLICATE;
      else if (full) status_o = ST_FULL;
      else begin
        status_o = ST_INSERTED;
        mem_wr   = 1'b1;
        head_wr  = !hvld_q[bkt];
        link_wr  = hvld_q[bkt];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && q_valid_i) cmd_q <= q_cmd_i;
    rkey_q  <= nkey_m[cur_q];
    rage_q  <= nage_m[cur_q];
    rname_q <= nname_m[cur_q];
    rcity_q <= ncity_m[cur_q];
    rlink_q <= nlink_m[cur_q];
    if (mem_wr) begin
      nkey_m[used_q[NW-1:0]]  <= cmd_q.key;
      nage_m[used_q[NW-1:0]]  <= cmd_q.age;
      nname_m[used_q[NW-1:0]] <= cmd_q.name;
      ncity_m[used_q[NW-1:0]] <= cmd_q.city;
      nlink_m[used_q[NW-1:0]] <= '0;
    end
    // Tail is cur_q: the walk ended on the last node of the chain.
    if (link_wr) nlink_m[cur_q] <= {1'b1, used_q[NW-1:0]};
    if (head_wr) head_q[bkt] <= used_q[NW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      cur_q   <= '0;
      used_q  <= '0;
      hvld_q  <= '0;
      found_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      cur_q <= cur_d;
      if (st_q == S_HEAD) found_q <= 1'b0;
      if (st_q == S_CHECK) found_q <= hit;
      if (mem_wr) used_q <= used_q + CW'(1);
      if (head_wr) hvld_q[bkt] <= 1'b1;
    end
  end
endmodule

// ----- hdl/chained_hash_table.sv -----
// ----------------------------------------------------------------------------
// chained_hash_table
// Hash table with separate chaining over a bump-allocated node pool.
// ----------------------------------------------------------------------------
// An operation leaves the queue in S_IDLE, reads the bucket head in S_HEAD, then
// visits L chain nodes (up to NODES) in S_READ and S_CHECK before S_DONE; each node
// costs one node-memory read and one key compare. A two-entry queue accepts new
// transactions while the walk runs; busy rises only when it is full.
// The result strobe done_o lasts one cycle and cannot be stalled.
module chained_hash_table #(
  parameter int unsigned BUCKETS = 16,
  parameter int unsigned NODES   = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       opcode_i,
  input  logic [cht_pkg::KeyW-1:0]   key_i,
  input  logic [cht_pkg::AgeW-1:0]   age_i,
  input  logic [cht_pkg::HdlW-1:0]   name_handle_i,
  input  logic [cht_pkg::HdlW-1:0]   city_handle_i,
  output logic                       done_o,
  output logic [cht_pkg::StW-1:0]    status_o,
  output logic [cht_pkg::AgeW-1:0]   found_age_o,
  output logic [cht_pkg::HdlW-1:0]   found_name_o,
  output logic [cht_pkg::HdlW-1:0]   found_city_o
);
  import cht_pkg::*;

  cmd_t    cmd, q_cmd;
  logic    q_valid, q_pop;
  status_e st;

  assign cmd = '{op: opcode_i, key: key_i, age: age_i, name: name_handle_i,
                 city: city_handle_i};
  assign status_o = st;

  cht_front u_front (
    .clk_i, .rst_ni, .start_i(start), .cmd_i(cmd), .busy_o(busy),
    .q_valid_o(q_valid), .q_cmd_o(q_cmd), .q_pop_i(q_pop)
  );

  cht_back #(.BUCKETS(BUCKETS), .NODES(NODES)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_cmd_i(q_cmd), .q_pop_o(q_pop),
    .done_o, .status_o(st), .age_o(found_age_o), .name_o(found_name_o),
    .city_o(found_city_o)
  );
endmodule

// ----- hdl/cht_checker.sv -----
// ----------------------------------------------------------------------------
// cht_checker
// Port-level checks of the chained hash table.
// ----------------------------------------------------------------------------
`include "chained_hash_table_assert.svh"
module cht_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        done_o,
  input logic [2:0]  status_o,
  input logic [7:0]  found_age_o,
  input logic [15:0] found_name_o,
  input logic [15:0] found_city_o
);
  import cht_pkg::*;

  `CHT_ASSERT_IMP(a_code, clk_i, rst_ni, done_o, status_o <= ST_MISSING)
  `CHT_ASSERT_IMP(a_zero, clk_i, rst_ni, done_o && status_o != ST_FOUND,
    found_age_o == 8'd0 && found_name_o == 16'd0 && found_city_o == 16'd0)
  `CHT_ASSERT_NEXT(a_gap, clk_i, rst_ni, done_o, !done_o)
endmodule

bind chained_hash_table cht_checker u_chk (.*);
